/* sv/mppd_pkg.sv */
// Shared constants, control-word layout and microcode program for the
// modular power / division block. No dependencies.
package mppd_pkg;

  // Residue width and modulus constants
  localparam int unsigned RES_W = 30;
  localparam logic [63:0] MOD_64 = 64'd998244353;
  localparam logic [31:0] MODULUS = 32'd998244353;
  localparam logic [31:0] MODULUS_X2 = 32'd1996488706;

  // Barrett factor floor(2^61 / M); fits in 32 bits
  localparam logic [63:0] MU_64 = (64'd1 << 61) / MOD_64;
  localparam logic [31:0] BARRETT_MU = MU_64[31:0];

  // 2^30 mod M, the weight of one operand chunk
  localparam logic [63:0] K30_64 = (64'd1 << 30) % MOD_64;
  localparam logic [RES_W-1:0] CHUNK_WEIGHT = K30_64[RES_W-1:0];

  // Fermat exponent M-2
  localparam logic [RES_W-1:0] EXP_INV = 30'd998244351;

  // Multiplier operations
  localparam logic [2:0] OP_NONE   = 3'd0;
  localparam logic [2:0] OP_HORNER = 3'd1;
  localparam logic [2:0] OP_MUL    = 3'd2;
  localparam logic [2:0] OP_SQR    = 3'd3;
  localparam logic [2:0] OP_DIV    = 3'd4;

  // Datapath actions
  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_LOAD_A    = 3'd1;
  localparam logic [2:0] ACT_SAVE_NUM  = 3'd2;
  localparam logic [2:0] ACT_SET_POW   = 3'd3;
  localparam logic [2:0] ACT_SHIFT_EXP = 3'd4;
  localparam logic [2:0] ACT_DONE      = 3'd5;

  // Jump conditions
  localparam logic [2:0] C_NEXT   = 3'd0;
  localparam logic [2:0] C_MODE0  = 3'd1;
  localparam logic [2:0] C_CNT_NZ = 3'd2;
  localparam logic [2:0] C_EXP_Z  = 3'd3;
  localparam logic [2:0] C_EXP_NZ = 3'd4;

  // Writeback destinations
  localparam logic DEST_ACC  = 1'b0;
  localparam logic DEST_BASE = 1'b1;

  // Program step addresses
  localparam int unsigned UPC_W = 4;
  localparam logic [UPC_W-1:0] U_INIT      = 4'd0;
  localparam logic [UPC_W-1:0] U_RED_A     = 4'd1;
  localparam logic [UPC_W-1:0] U_RED_A_W   = 4'd2;
  localparam logic [UPC_W-1:0] U_SAVE_NUM  = 4'd3;
  localparam logic [UPC_W-1:0] U_RED_B     = 4'd4;
  localparam logic [UPC_W-1:0] U_RED_B_W   = 4'd5;
  localparam logic [UPC_W-1:0] U_SET_POW   = 4'd6;
  localparam logic [UPC_W-1:0] U_EXP_TEST  = 4'd7;
  localparam logic [UPC_W-1:0] U_MUL       = 4'd8;
  localparam logic [UPC_W-1:0] U_SQR       = 4'd9;
  localparam logic [UPC_W-1:0] U_EXP_W     = 4'd10;
  localparam logic [UPC_W-1:0] U_MODE_TEST = 4'd11;
  localparam logic [UPC_W-1:0] U_DIV       = 4'd12;
  localparam logic [UPC_W-1:0] U_DIV_W     = 4'd13;
  localparam logic [UPC_W-1:0] U_DONE      = 4'd14;

  typedef struct packed {
    logic [2:0]       op;
    logic [2:0]       act;
    logic [2:0]       cond;
    logic             wait_pipe;
    logic [UPC_W-1:0] target;
  } ucode_t;

  // Microcode ROM: one control word per step
  function automatic ucode_t ucode_rom(input logic [UPC_W-1:0] addr);
    ucode_t w;
    w.op        = OP_NONE;
    w.act       = ACT_NONE;
    w.cond      = C_NEXT;
    w.wait_pipe = 1'b0;
    w.target    = U_INIT;
    case (addr)
      U_INIT: begin
        w.act    = ACT_LOAD_A;
        w.cond   = C_MODE0;
        w.target = U_RED_B;
      end
      U_RED_A: begin
        w.op = OP_HORNER;
      end
      U_RED_A_W: begin
        w.wait_pipe = 1'b1;
        w.cond      = C_CNT_NZ;
        w.target    = U_RED_A;
      end
      U_SAVE_NUM: begin
        w.act = ACT_SAVE_NUM;
      end
      U_RED_B: begin
        w.op = OP_HORNER;
      end
      U_RED_B_W: begin
        w.wait_pipe = 1'b1;
        w.cond      = C_CNT_NZ;
        w.target    = U_RED_B;
      end
      U_SET_POW: begin
        w.act = ACT_SET_POW;
      end
      U_EXP_TEST: begin
        w.cond   = C_EXP_Z;
        w.target = U_MODE_TEST;
      end
      U_MUL: begin
        w.op = OP_MUL;
      end
      U_SQR: begin
        w.op  = OP_SQR;
        w.act = ACT_SHIFT_EXP;
      end
      U_EXP_W: begin
        w.wait_pipe = 1'b1;
        w.cond      = C_EXP_NZ;
        w.target    = U_MUL;
      end
      U_MODE_TEST: begin
        w.cond   = C_MODE0;
        w.target = U_DONE;
      end
      U_DIV: begin
        w.op = OP_DIV;
      end
      U_DIV_W: begin
        w.wait_pipe = 1'b1;
      end
      U_DONE: begin
        w.act = ACT_DONE;
      end
      default: begin
        w.act = ACT_DONE;
      end
    endcase
    return w;
  endfunction

endpackage

/* sv/mod_prime_power_and_divide.sv */
// Modular power a^b and modular division a/b over the prime 998244353.
// A microcode sequencer drives one pipelined Barrett modular multiplier.
// Depends on mppd_pkg.
//
// Mode 0 returns operand_a^operand_b mod 998244353 (right-to-left square and
// multiply; a zero exponent gives 1), mode 1 returns operand_a times
// operand_b^(M-2), so a divisor that is 0 mod M gives 0. One word is in
// flight at a time: in_stall is high from acceptance until the result is
// loaded into the output register, which may still be waiting on out_stall
// when the next word is taken. Run time is set by the pipelined modular
// multiplier and by each square depending on the previous one: an operand
// is reduced one 30-bit chunk at a time, and the exponent is scanned one
// bit at a time up to its highest set bit.
module mod_prime_power_and_divide #(
  parameter int unsigned OPERAND_BITS = 63
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic                         in_mode,
  input  logic [OPERAND_BITS-1:0]      in_operand_a,
  input  logic [OPERAND_BITS-1:0]      in_operand_b,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic [mppd_pkg::RES_W-1:0]   out_residue
);

  localparam int unsigned RW     = mppd_pkg::RES_W;
  localparam int unsigned CHUNKS = (OPERAND_BITS + RW - 1) / RW;
  localparam int unsigned SR_W   = CHUNKS * RW;
  localparam int unsigned CNT_W  = $clog2(CHUNKS + 1);

  // Sequencer state
  logic                          busy_r;
  logic [mppd_pkg::UPC_W-1:0]    upc_r;
  mppd_pkg::ucode_t              cw;
  logic                          hold;
  logic                          fire;
  logic                          jump;
  logic                          accept;

  // Datapath registers
  logic                          mode_r;
  logic [OPERAND_BITS-1:0]       opa_r;
  logic [OPERAND_BITS-1:0]       opb_r;
  logic [SR_W-1:0]               sr_r;
  logic [CNT_W-1:0]              cnt_r;
  logic [RW-1:0]                 acc_r;
  logic [RW-1:0]                 base_r;
  logic [RW-1:0]                 num_r;
  logic [OPERAND_BITS-1:0]       exp_r;
  logic                          out_valid_r;
  logic [RW-1:0]                 out_residue_r;

  // Multiplier issue
  logic                          iss_v;
  logic                          iss_dest;
  logic [RW-1:0]                 mul_x;
  logic [RW-1:0]                 mul_y;
  logic [RW-1:0]                 mul_z;
  logic [2*RW-1:0]               mul_prod;
  logic [2*RW:0]                 p1_nxt;

  // Multiplier pipeline
  logic                          v1_r, v2_r, v3_r, v4_r;
  logic                          d1_r, d2_r, d3_r, d4_r;
  logic [2*RW:0]                 p1_r;
  logic [63:0]                   q_full;
  logic [31:0]                   q2_r;
  logic [31:0]                   p2_r;
  logic [31:0]                   qm_lo;
  logic [31:0]                   qm3_r;
  logic [31:0]                   p3_r;
  logic [31:0]                   r4_r;
  logic [31:0]                   wb_r1;
  logic [31:0]                   wb_r2;
  logic [RW-1:0]                 wb_res;
  logic                          wb_acc;
  logic                          wb_base;
  logic                          pipe_busy;

  // Handshake
  assign in_stall    = busy_r;
  assign accept      = in_valid && !busy_r;
  assign out_valid   = out_valid_r;
  assign out_residue = out_residue_r;

  // Fetch control word and decide hold / jump
  assign cw        = mppd_pkg::ucode_rom(upc_r);
  assign pipe_busy = v1_r || v2_r || v3_r;
  assign hold      = (cw.wait_pipe && pipe_busy) ||
                     (cw.act == mppd_pkg::ACT_DONE && out_valid_r && out_stall);
  assign fire      = busy_r && !hold;

  always_comb begin
    case (cw.cond)
      mppd_pkg::C_NEXT:   jump = 1'b0;
      mppd_pkg::C_MODE0:  jump = !mode_r;
      mppd_pkg::C_CNT_NZ: jump = (cnt_r != '0);
      mppd_pkg::C_EXP_Z:  jump = (exp_r == '0);
      mppd_pkg::C_EXP_NZ: jump = (exp_r != '0);
      default:            jump = 1'b0;
    endcase
  end

  // Advance step counter
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      upc_r  <= mppd_pkg::U_INIT;
    end else if (accept) begin
      busy_r <= 1'b1;
      upc_r  <= mppd_pkg::U_INIT;
    end else if (fire) begin
      if (cw.act == mppd_pkg::ACT_DONE) begin
        busy_r <= 1'b0;
        upc_r  <= mppd_pkg::U_INIT;
      end else if (jump) begin
        upc_r <= cw.target;
      end else begin
        upc_r <= upc_r + 1'b1;
      end
    end
  end

  // Select multiplier operands for the issued operation
  always_comb begin
    iss_v    = 1'b0;
    iss_dest = mppd_pkg::DEST_ACC;
    mul_x    = acc_r;
    mul_y    = base_r;
    mul_z    = '0;
    if (fire) begin
      case (cw.op)
        mppd_pkg::OP_HORNER: begin
          iss_v = 1'b1;
          mul_y = mppd_pkg::CHUNK_WEIGHT;
          mul_z = sr_r[SR_W-1 -: RW];
        end
        mppd_pkg::OP_MUL: begin
          iss_v = exp_r[0];
        end
        mppd_pkg::OP_SQR: begin
          iss_v    = 1'b1;
          iss_dest = mppd_pkg::DEST_BASE;
          mul_x    = base_r;
        end
        mppd_pkg::OP_DIV: begin
          iss_v = 1'b1;
          mul_y = num_r;
        end
        default: begin
          iss_v = 1'b0;
        end
      endcase
    end
  end

  // Stage 1: product plus addend
  assign mul_prod = mul_x * mul_y;
  assign p1_nxt   = {1'b0, mul_prod} + {{(RW + 1){1'b0}}, mul_z};

  // Stage 2: Barrett quotient estimate
  assign q_full = p1_r[2*RW:29] * mppd_pkg::BARRETT_MU;

  // Stage 3: quotient times modulus, low word only
  assign qm_lo = q2_r * mppd_pkg::MODULUS;

  // Writeback: remainder is below 3M, fold it down
  always_comb begin
    wb_r1  = (r4_r >= mppd_pkg::MODULUS_X2) ? r4_r - mppd_pkg::MODULUS_X2 : r4_r;
    wb_r2  = (wb_r1 >= mppd_pkg::MODULUS) ? wb_r1 - mppd_pkg::MODULUS : wb_r1;
    wb_res = wb_r2[RW-1:0];
  end

  assign wb_acc  = v4_r && (d4_r == mppd_pkg::DEST_ACC);
  assign wb_base = v4_r && (d4_r == mppd_pkg::DEST_BASE);

  // Advance pipeline valids and tags
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      v1_r <= iss_v;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  // Advance pipeline payload
  always_ff @(posedge clk) begin
    d1_r  <= iss_dest;
    d2_r  <= d1_r;
    d3_r  <= d2_r;
    d4_r  <= d3_r;
    p1_r  <= p1_nxt;
    q2_r  <= q_full[63:32];
    p2_r  <= p1_r[31:0];
    qm3_r <= qm_lo;
    p3_r  <= p2_r;
    r4_r  <= p3_r - qm3_r;
  end

  // Capture operands on accept
  always_ff @(posedge clk) begin
    if (accept) begin
      mode_r <= in_mode;
      opa_r  <= in_operand_a;
      opb_r  <= in_operand_b;
    end
  end

  // Chunk shifter and chunk count for operand reduction
  always_ff @(posedge clk) begin
    if (fire && cw.act == mppd_pkg::ACT_LOAD_A) begin
      sr_r  <= SR_W'(opa_r);
      cnt_r <= CNT_W'(CHUNKS);
    end else if (fire && cw.act == mppd_pkg::ACT_SAVE_NUM) begin
      sr_r  <= SR_W'(opb_r);
      cnt_r <= CNT_W'(CHUNKS);
    end else if (fire && cw.op == mppd_pkg::OP_HORNER) begin
      sr_r  <= sr_r << RW;
      cnt_r <= cnt_r - 1'b1;
    end
  end

  // Accumulator, base, numerator and exponent
  always_ff @(posedge clk) begin
    if (wb_acc) begin
      acc_r <= wb_res;
    end else if (fire && (cw.act == mppd_pkg::ACT_LOAD_A ||
                          cw.act == mppd_pkg::ACT_SAVE_NUM)) begin
      acc_r <= '0;
    end else if (fire && cw.act == mppd_pkg::ACT_SET_POW) begin
      acc_r <= RW'(1);
    end

    if (wb_base) begin
      base_r <= wb_res;
    end else if (fire && cw.act == mppd_pkg::ACT_SET_POW) begin
      base_r <= acc_r;
    end

    if (fire && cw.act == mppd_pkg::ACT_SAVE_NUM) begin
      num_r <= acc_r;
    end

    if (fire && cw.act == mppd_pkg::ACT_SET_POW) begin
      exp_r <= mode_r ? OPERAND_BITS'(mppd_pkg::EXP_INV) : opb_r;
    end else if (fire && cw.act == mppd_pkg::ACT_SHIFT_EXP) begin
      exp_r <= exp_r >> 1;
    end
  end

  // Output register: load on done, drop when taken
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (fire && cw.act == mppd_pkg::ACT_DONE) begin
      out_valid_r <= 1'b1;
    end else if (out_valid_r && !out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire && cw.act == mppd_pkg::ACT_DONE) begin
      out_residue_r <= acc_r;
    end
  end

  // Multiplier is drained whenever the sequencer is idle
  a_idle_pipe_empty: assert property (@(posedge clk) disable iff (!rst_n)
    !busy_r |-> !(v1_r || v2_r || v3_r || v4_r))
    else $error("multiplier busy while sequencer idle");

  // A delivered residue is fully reduced
  a_residue_reduced: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> ({2'b00, out_residue_r} < mppd_pkg::MODULUS))
    else $error("residue not reduced");

  // Finishing a word frees the input and shows the result
  a_done_handoff: assert property (@(posedge clk) disable iff (!rst_n)
    (fire && cw.act == mppd_pkg::ACT_DONE) |=> (!busy_r && out_valid_r))
    else $error("done step did not hand off");

  // Step counter stays inside the program
  a_upc_range: assert property (@(posedge clk) disable iff (!rst_n)
    busy_r |-> (upc_r <= mppd_pkg::U_DONE))
    else $error("step counter out of program");

endmodule

/* tb/sv/mppd_tb_pkg.sv */
`timescale 1ns / 100ps
// Operating modes and the prime modulus shared by the power/divide checker
// and the test top. No dependencies.
package mppd_tb_pkg;

  typedef enum logic {
    MODE_POWER  = 1'b0,
    MODE_DIVIDE = 1'b1
  } mode_t;

  localparam logic [63:0] PRIME = 64'd998244353;

endpackage

/* tb/sv/mppd_residue_checker.sv */
`timescale 1ns / 100ps
// Channel monitor for mod_prime_power_and_divide: predicts each residue
// from the accepted input word and compares it with the output word.
// Depends on mppd_pkg and mppd_tb_pkg.
module mppd_residue_checker #(
  parameter int unsigned OPERAND_BITS = 63
) (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       in_valid,
  input  logic                       in_stall,
  input  logic                       in_mode,
  input  logic [OPERAND_BITS-1:0]    in_operand_a,
  input  logic [OPERAND_BITS-1:0]    in_operand_b,
  input  logic                       out_valid,
  input  logic                       out_stall,
  input  logic [mppd_pkg::RES_W-1:0] out_residue,
  output int                         fail_count,
  output int                         pending
);

  logic [mppd_pkg::RES_W-1:0] expected_residues[$];
  logic [mppd_pkg::RES_W-1:0] oldest_residue;
  int                         word_index;

  initial begin
    fail_count = 0;
    pending    = 0;
    word_index = 0;
  end

  // Right-to-left square and multiply; a zero exponent leaves 1
  function automatic logic [63:0] raise_mod(logic [63:0] base, logic [63:0] expo);
    logic [63:0] acc;
    acc  = 64'd1;
    base = base % mppd_tb_pkg::PRIME;
    while (expo != 64'd0) begin
      if (expo[0]) begin
        acc = (acc * base) % mppd_tb_pkg::PRIME;
      end
      base = (base * base) % mppd_tb_pkg::PRIME;
      expo = expo >> 1;
    end
    return acc;
  endfunction

  // Power in one mode, numerator times Fermat inverse in the other
  function automatic logic [mppd_pkg::RES_W-1:0] predict_residue(
    mppd_tb_pkg::mode_t mode, logic [OPERAND_BITS-1:0] a, logic [OPERAND_BITS-1:0] b);
    logic [63:0] r;
    if (mode == mppd_tb_pkg::MODE_POWER) begin
      r = raise_mod(64'(a), 64'(b));
    end else begin
      r = ((64'(a) % mppd_tb_pkg::PRIME) *
           raise_mod(64'(b), mppd_tb_pkg::PRIME - 64'd2)) % mppd_tb_pkg::PRIME;
    end
    return r[mppd_pkg::RES_W-1:0];
  endfunction

  task automatic report_mismatch(string msg);
    $display("%0t ns: residue check: %s", $time, msg);
    fail_count++;
  endtask

  always @(posedge clk) begin
    if (rst_n) begin
      // Retire the oldest expectation against the output word
      if (out_valid && !out_stall) begin
        if (expected_residues.size() == 0) begin
          report_mismatch($sformatf("word %0d: unexpected residue %0d",
                                    word_index, out_residue));
        end else begin
          oldest_residue = expected_residues.pop_front();
          if (out_residue !== oldest_residue) begin
            report_mismatch($sformatf("word %0d: residue %0d, want %0d",
                                      word_index, out_residue, oldest_residue));
          end
        end
        word_index++;
      end
      // Queue the prediction for an accepted input word
      if (in_valid && !in_stall) begin
        expected_residues = {expected_residues,
          predict_residue(mppd_tb_pkg::mode_t'(in_mode), in_operand_a, in_operand_b)};
      end
      pending = expected_residues.size();
    end
  end

endmodule

/* tb/sv/mod_prime_power_and_divide_test.sv */
`timescale 1ns / 100ps
// Test top for mod_prime_power_and_divide: drives directed and random words
// with random idling and gives the verdict. Depends on mppd_tb_pkg,
// mppd_residue_checker and the block's RTL.
module mod_prime_power_and_divide_test;

  localparam int unsigned OPERAND_BITS     = 63;
  localparam logic [OPERAND_BITS-1:0] ALL_ONES = '1;
  localparam logic [OPERAND_BITS-1:0] TOP_BIT  = 63'd1 << 62;
  localparam int          RANDOM_PER_PHASE = 384;
  localparam int          SETTLE_CYCLES    = 450;

  logic                       clk          = 1'b0;
  logic                       rst_n        = 1'b0;
  logic                       in_valid     = 1'b0;
  logic                       in_mode      = 1'b0;
  logic [OPERAND_BITS-1:0]    in_operand_a = '0;
  logic [OPERAND_BITS-1:0]    in_operand_b = '0;
  logic                       out_stall    = 1'b0;
  logic                       in_stall;
  logic                       out_valid;
  logic [mppd_pkg::RES_W-1:0] out_residue;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int          fail_count;
  int          pending;

  mod_prime_power_and_divide #(
    .OPERAND_BITS(OPERAND_BITS)
  ) DUT (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_residue (out_residue)
  );

  mppd_residue_checker #(
    .OPERAND_BITS(OPERAND_BITS)
  ) u_checker (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .in_mode     (in_mode),
    .in_operand_a(in_operand_a),
    .in_operand_b(in_operand_b),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_residue (out_residue),
    .fail_count  (fail_count),
    .pending     (pending)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  // Stop a hung run
  initial begin
    #12_000_000;
    $display("mod_prime_power_and_divide_test NOT OK");
    $finish;
  end

  // Stall the output at random
  always @(negedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  // Present one word, after a random gap, and hold it until taken
  task automatic send_word(mppd_tb_pkg::mode_t mode, logic [OPERAND_BITS-1:0] a,
                           logic [OPERAND_BITS-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid     <= 1'b1;
    in_mode      <= mode;
    in_operand_a <= a;
    in_operand_b <= b;
    do @(posedge clk); while (in_stall);
    @(negedge clk);
  endtask

  // Drop valid and wait for every outstanding residue
  task automatic hold_until_drained();
    in_valid <= 1'b0;
    @(negedge clk);
    while (pending != 0) @(negedge clk);
  endtask

  // Mix of small values, multiples of the prime, near-max, random widths, full random
  function automatic logic [OPERAND_BITS-1:0] random_operand();
    logic [63:0] raw;
    logic [63:0] v;
    int unsigned w;
    raw = {$urandom, $urandom};
    case ($urandom_range(5))
      0: v = 64'($urandom_range(15));
      1: v = mppd_tb_pkg::PRIME * 64'($urandom) + 64'($urandom_range(2));
      2: v = 64'(ALL_ONES) - 64'($urandom_range(3));
      3, 4: begin
        w = $urandom_range(63);
        v = raw & ((64'd1 << w) - 64'd1);
      end
      default: v = raw;
    endcase
    return v[OPERAND_BITS-1:0];
  endfunction

  task automatic run_random(int count);
    mppd_tb_pkg::mode_t mode;
    repeat (count) begin
      mode = ($urandom_range(1) == 0) ? mppd_tb_pkg::MODE_POWER : mppd_tb_pkg::MODE_DIVIDE;
      send_word(mode, random_operand(), random_operand());
    end
  endtask

  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    send_idle_pct = 26;
    recv_idle_pct = 77;

    // Zero exponent, including a base that is a multiple of the prime
    send_word(mppd_tb_pkg::MODE_POWER, 63'd0, 63'd0);
    send_word(mppd_tb_pkg::MODE_POWER, 63'(mppd_tb_pkg::PRIME), 63'd0);
    send_word(mppd_tb_pkg::MODE_POWER, ALL_ONES, 63'd0);
    // Power corners and field extremes
    send_word(mppd_tb_pkg::MODE_POWER, 63'd0, 63'd1);
    send_word(mppd_tb_pkg::MODE_POWER, 63'd0, ALL_ONES);
    send_word(mppd_tb_pkg::MODE_POWER, 63'(2 * mppd_tb_pkg::PRIME), 63'd7);
    send_word(mppd_tb_pkg::MODE_POWER, ALL_ONES, ALL_ONES);
    send_word(mppd_tb_pkg::MODE_POWER, 63'd3, 63'd1);
    send_word(mppd_tb_pkg::MODE_POWER, 63'(mppd_tb_pkg::PRIME - 1), 63'd2);
    send_word(mppd_tb_pkg::MODE_POWER, 63'(mppd_tb_pkg::PRIME + 2),
              63'(mppd_tb_pkg::PRIME - 1));
    send_word(mppd_tb_pkg::MODE_POWER, 63'd2, TOP_BIT);
    send_word(mppd_tb_pkg::MODE_POWER, TOP_BIT, 63'd5);
    send_word(mppd_tb_pkg::MODE_POWER, 63'd1, ALL_ONES);
    // Divisor congruent to zero gives zero
    send_word(mppd_tb_pkg::MODE_DIVIDE, 63'd0, 63'd0);
    send_word(mppd_tb_pkg::MODE_DIVIDE, 63'd5, 63'd0);
    send_word(mppd_tb_pkg::MODE_DIVIDE, 63'd7, 63'(mppd_tb_pkg::PRIME));
    // Division corners and field extremes
    send_word(mppd_tb_pkg::MODE_DIVIDE, ALL_ONES, ALL_ONES);
    send_word(mppd_tb_pkg::MODE_DIVIDE, ALL_ONES, 63'd1);
    send_word(mppd_tb_pkg::MODE_DIVIDE, 63'(mppd_tb_pkg::PRIME - 1),
              63'(mppd_tb_pkg::PRIME - 1));
    send_word(mppd_tb_pkg::MODE_DIVIDE, 63'd1, 63'(2 * mppd_tb_pkg::PRIME + 3));
    send_word(mppd_tb_pkg::MODE_DIVIDE, 63'd0, ALL_ONES);
    send_word(mppd_tb_pkg::MODE_DIVIDE, 63'd12345, 63'(mppd_tb_pkg::PRIME + 1));
    send_word(mppd_tb_pkg::MODE_DIVIDE, TOP_BIT, TOP_BIT);
    send_word(mppd_tb_pkg::MODE_DIVIDE, 63'(3 * mppd_tb_pkg::PRIME), 63'd2);

    run_random(RANDOM_PER_PHASE);
    hold_until_drained();

    send_idle_pct = 77;
    recv_idle_pct = 26;
    run_random(RANDOM_PER_PHASE);
    hold_until_drained();

    send_idle_pct = 0;
    recv_idle_pct = 0;
    run_random(RANDOM_PER_PHASE);

    // Drain and let any stray word show up
    in_valid <= 1'b0;
    @(negedge clk);
    wait (pending == 0);
    repeat (SETTLE_CYCLES) @(posedge clk);

    if (fail_count == 0 && pending == 0) begin
      $display("mod_prime_power_and_divide_test OK");
    end else begin
      $display("mod_prime_power_and_divide_test NOT OK");
    end
    $finish;
  end

endmodule
